### design/srip_pkg.sv
package srip_pkg;

  // Default geometry
  localparam int DEF_NUM_SETS = 64;
  localparam int DEF_MAX_WAYS = 8;

  // Fixed field widths
  localparam int SET_NUM_W = 6;
  localparam int WAY_NUM_W = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Pseudo-random source
  localparam int             LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam int             BIP_ODDS  = 64;
  localparam int             BIP_BITS  = $clog2(BIP_ODDS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INSERT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VICTIM_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

  typedef enum logic [1:0] {
    INS_MRU  = 2'd0,
    INS_LIP  = 2'd1,
    INS_BIP  = 2'd2,
    INS_FIFO = 2'd3
  } insert_mode_t;

  typedef enum logic {
    VIC_LRU    = 1'b0,
    VIC_RANDOM = 1'b1
  } victim_mode_t;

  // Work the back part carries out for one queued item.
  typedef enum logic [2:0] {
    OP_FRONT    = 3'd0,
    OP_TAIL     = 3'd1,
    OP_BIP      = 3'd2,
    OP_VIC_TAIL = 3'd3,
    OP_VIC_RAND = 3'd4
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [WAY_NUM_W-1:0] way;
  } bk_item_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC,
    BK_DIV
  } back_state_t;

  // One step of the Fibonacci LFSR with taps 16, 14, 13, 11.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

endpackage

### design/set_recency_insertion_policy.sv
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+--------------------------------
// input    | in_command, in_set_index, in_way_number,      | start high and busy low at a
//          | in_first_fill                                 | rising edge
// result   | out_victim_way                                | out_valid high for one cycle
// config   | cfg_we, cfg_index, cfg_wdata                  | cfg_we high at a rising edge
//
// A commit or a tail-victim request does one row read and then one row write (or result) in
// the back part, on the single-port set memory. A random-victim request also waits for the
// bit-serial remainder unit that reduces the LFSR value by the number of ways. After reset
// the block runs a clearing pass that writes the identity order into every row; busy stays
// high during it. Busy also rises when the two-entry queue between the front and back parts
// is full. The receiver cannot stall.
module set_recency_insertion_policy import srip_pkg::*; #(
  parameter int NUM_SETS = DEF_NUM_SETS,
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [SET_NUM_W-1:0] in_set_index,
  input  logic [WAY_NUM_W-1:0] in_way_number,
  input  logic                 in_first_fill,
  output logic                 out_valid,
  output logic [WAY_NUM_W-1:0] out_victim_way,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Set memory address width; a single set still gets a one-bit address.
  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  // Width that can hold a way count from 1 up to MAX_WAYS.
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);

  insert_mode_t         insert_mode_r;
  victim_mode_t         victim_mode_r;
  logic [CFG_W-1:0]     ways_in_use_r;
  logic [WAY_CNT_W-1:0] ways_eff;

  logic             clearing;
  logic             q_valid;
  logic             q_pop;
  bk_item_t         q_item;
  logic [SET_W-1:0] q_set;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      insert_mode_r <= INS_MRU;
      victim_mode_r <= VIC_LRU;
      ways_in_use_r <= WAYS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INSERT_MODE: insert_mode_r <= insert_mode_t'(cfg_wdata[1:0]);
        CFG_VICTIM_MODE: victim_mode_r <= victim_mode_t'(cfg_wdata[0]);
        CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The number of ways in use saturates into 1..MAX_WAYS, so zero acts as one way.
  always_comb begin
    if (ways_in_use_r == '0) begin
      ways_eff = WAY_CNT_W'(1);
    end else if (32'(ways_in_use_r) > MAX_WAYS) begin
      ways_eff = WAY_CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAY_CNT_W'(ways_in_use_r);
    end
  end

  // The front part takes commands, reduces the set index and decides what the
  // back part must do; FIFO-mode hits are dropped here since they change nothing.
  srip_front #(
    .NUM_SETS (NUM_SETS),
    .SET_W    (SET_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_set_index  (in_set_index),
    .in_way_number (in_way_number),
    .in_first_fill (in_first_fill),
    .insert_mode   (insert_mode_r),
    .victim_mode   (victim_mode_r),
    .clearing      (clearing),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_set         (q_set),
    .q_pop         (q_pop)
  );

  // The back part owns the recency rows and the LFSR, and works one item at a time,
  // so a row is always written back before the next item reads it.
  srip_back #(
    .NUM_SETS  (NUM_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .SET_W     (SET_W),
    .WAY_CNT_W (WAY_CNT_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ways_eff       (ways_eff),
    .clearing       (clearing),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_set          (q_set),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_victim_way (out_victim_way)
  );

endmodule

### design/srip_rem.sv
module srip_rem import srip_pkg::*; #(
  parameter int DIV_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LFSR_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIV_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(LFSR_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LFSR_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W:0]    trial;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    trial    = {rem_r, dvd_r[LFSR_W-1]};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      dvd_nxt = {dvd_r[LFSR_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DIV_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = DIV_W'(trial);
      end
      if (cnt_r == CNT_W'(LFSR_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### design/srip_front.sv
module srip_front import srip_pkg::*; #(
  parameter int NUM_SETS = DEF_NUM_SETS,
  parameter int SET_W    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [SET_NUM_W-1:0] in_set_index,
  input  logic [WAY_NUM_W-1:0] in_way_number,
  input  logic                 in_first_fill,
  input  insert_mode_t         insert_mode,
  input  victim_mode_t         victim_mode,
  input  logic                 clearing,
  output logic                 q_valid,
  output bk_item_t             q_item,
  output logic [SET_W-1:0]     q_set,
  input  logic                 q_pop
);

  localparam int QD    = 2;
  localparam int QPW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);

  logic             accept;
  logic             keep;
  bk_item_t         item;
  logic [SET_W-1:0] set_red;

  bk_item_t         q_item_r [QD];
  logic [SET_W-1:0] q_set_r  [QD];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             push;

  // Reduce the set index into the number of sets.
  if (NUM_SETS >= (1 << SET_NUM_W)) begin : g_wide
    assign set_red = SET_W'(in_set_index);
  end else begin : g_reduce
    localparam int RSH   = 13;
    localparam int RECIP = ((1 << RSH) + NUM_SETS - 1) / NUM_SETS;
    localparam int PW    = SET_NUM_W + RSH + 1;
    logic [PW-1:0]          prod;
    logic [SET_NUM_W-1:0]   quot;
    logic [2*SET_NUM_W-1:0] qd;
    logic [SET_NUM_W-1:0]   rem;
    assign prod    = PW'(in_set_index) * PW'(RECIP);
    assign quot    = prod[RSH +: SET_NUM_W];
    assign qd      = (2*SET_NUM_W)'(quot) * (2*SET_NUM_W)'(NUM_SETS);
    assign rem     = in_set_index - qd[SET_NUM_W-1:0];
    assign set_red = SET_W'(rem);
  end

  // Classify the command against the current modes.
  always_comb begin
    keep     = 1'b1;
    item.way = in_way_number;
    item.op  = OP_FRONT;
    if (in_command) begin
      item.op = (victim_mode == VIC_RANDOM) ? OP_VIC_RAND : OP_VIC_TAIL;
    end else begin
      unique case (insert_mode)
        INS_MRU:  item.op = OP_FRONT;
        INS_LIP:  item.op = in_first_fill ? OP_TAIL : OP_FRONT;
        INS_BIP:  item.op = in_first_fill ? OP_BIP : OP_FRONT;
        INS_FIFO: keep    = in_first_fill;
      endcase
    end
  end

  assign busy    = (count_r == QCW'(QD)) || clearing;
  assign accept  = start && !busy;
  assign push    = accept && keep;
  assign q_valid = (count_r != '0);
  assign q_item  = q_item_r[rd_ptr_r];
  assign q_set   = q_set_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_item_r[wr_ptr_r] <= item;
      q_set_r[wr_ptr_r]  <= set_red;
    end
  end

endmodule

### design/srip_back.sv
module srip_back import srip_pkg::*; #(
  parameter int NUM_SETS  = DEF_NUM_SETS,
  parameter int MAX_WAYS  = DEF_MAX_WAYS,
  parameter int SET_W     = 6,
  parameter int WAY_CNT_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WAY_CNT_W-1:0] ways_eff,
  output logic                 clearing,
  input  logic                 q_valid,
  input  bk_item_t             q_item,
  input  logic [SET_W-1:0]     q_set,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [WAY_NUM_W-1:0] out_victim_way
);

  localparam int WAY_W = $clog2(MAX_WAYS);
  localparam int ENT_W = (WAY_W > WAY_NUM_W) ? WAY_W : WAY_NUM_W;
  localparam int ROW_W = MAX_WAYS * ENT_W;

  back_state_t state_r, state_nxt;

  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rd_row_r;
  logic             mem_re, mem_we;
  logic [ROW_W-1:0] wdata;
  logic [SET_W-1:0] waddr;

  logic [SET_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WAY_NUM_W-1:0] out_way_r, out_way_nxt;

  op_t                  op_r;
  logic [WAY_NUM_W-1:0] way_r;
  logic [SET_W-1:0]     set_r;

  logic [ENT_W-1:0] cur      [MAX_WAYS];
  logic [ENT_W-1:0] front_v  [MAX_WAYS];
  logic [ENT_W-1:0] tail_v   [MAX_WAYS];
  logic [ROW_W-1:0] ident_row, front_row, tail_row;
  logic [MAX_WAYS-1:0] match;
  logic             found;
  logic [WAY_W-1:0] pos, last, fpos;
  logic [ENT_W-1:0] way_ext;

  logic                 div_start, div_done;
  logic [WAY_CNT_W-1:0] div_rem;
  logic [LFSR_W-1:0]    rem_ext;

  srip_rem #(
    .DIV_W (WAY_CNT_W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (lfsr_nxt),
    .divisor   (ways_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign rem_ext = LFSR_W'(div_rem);
  assign way_ext = ENT_W'(way_r);
  assign last    = WAY_W'(ways_eff - WAY_CNT_W'(1));

  // Locate the way among the live entries, then build both reorderings.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      cur[i]   = rd_row_r[i*ENT_W +: ENT_W];
      match[i] = (WAY_CNT_W'(i) < ways_eff) && (cur[i] == way_ext);
      ident_row[i*ENT_W +: ENT_W] = ENT_W'(i);
    end
    found = |match;
    pos   = last;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = WAY_W'(i);
      end
    end
    fpos = found ? pos : last;

    front_v[0] = way_ext;
    for (int i = 1; i < MAX_WAYS; i++) begin
      front_v[i] = (WAY_W'(i) <= fpos) ? cur[i-1] : cur[i];
    end

    for (int i = 0; i < MAX_WAYS - 1; i++) begin
      if (WAY_W'(i) < pos) begin
        tail_v[i] = cur[i];
      end else if (WAY_W'(i) < last) begin
        tail_v[i] = cur[i+1];
      end else if (WAY_W'(i) == last) begin
        tail_v[i] = way_ext;
      end else begin
        tail_v[i] = cur[i];
      end
    end
    tail_v[MAX_WAYS-1] = (WAY_W'(MAX_WAYS - 1) == last) ? way_ext : cur[MAX_WAYS-1];

    for (int i = 0; i < MAX_WAYS; i++) begin
      front_row[i*ENT_W +: ENT_W] = front_v[i];
      tail_row[i*ENT_W +: ENT_W]  = tail_v[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    wdata         = front_row;
    waddr         = set_r;
    clr_addr_nxt  = clr_addr_r;
    lfsr_nxt      = lfsr_r;
    div_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_way_nxt   = out_way_r;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        wdata        = ident_row;
        waddr        = clr_addr_r;
        clr_addr_nxt = clr_addr_r + SET_W'(1);
        if (clr_addr_r == SET_W'(NUM_SETS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          mem_re    = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        state_nxt = BK_IDLE;
        unique case (op_r)
          OP_FRONT: begin
            mem_we = 1'b1;
          end
          OP_TAIL: begin
            mem_we = 1'b1;
            wdata  = found ? tail_row : front_row;
          end
          OP_BIP: begin
            lfsr_nxt = lfsr_step(lfsr_r);
            mem_we   = 1'b1;
            if (found && (lfsr_nxt[BIP_BITS-1:0] != '0)) begin
              wdata = tail_row;
            end
          end
          OP_VIC_TAIL: begin
            out_valid_nxt = 1'b1;
            out_way_nxt   = cur[last][WAY_NUM_W-1:0];
          end
          OP_VIC_RAND: begin
            lfsr_nxt  = lfsr_step(lfsr_r);
            div_start = 1'b1;
            state_nxt = BK_DIV;
          end
          default: begin
          end
        endcase
      end
      BK_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_way_nxt   = rem_ext[WAY_NUM_W-1:0];
          state_nxt     = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      lfsr_r      <= LFSR_SEED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_way_r <= out_way_nxt;
    if (q_pop) begin
      op_r  <= q_item.op;
      way_r <= q_item.way;
      set_r <= q_set;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_row_r <= mem[q_set];
    end
  end

  assign clearing       = (state_r == BK_CLEAR);
  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;

`ifndef ASSERT_OFF
  a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two results in consecutive cycles");

  a_no_victim_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != BK_CLEAR) |->
      (op_r == OP_FRONT || op_r == OP_TAIL || op_r == OP_BIP))
    else $error("row written by a victim request");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == BK_DIV)
    else $error("remainder finished outside its wait state");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("LFSR reached the all-zero lockup state");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop && !out_valid_r)
    else $error("item taken while rows are being initialized");
`endif

endmodule

### dv/tb_set_recency_insertion_policy.sv
`timescale 1ns / 1ps

// Tracks the recency order of every set, the random source and the three
// registers, and keeps the victim ways that the block still owes.
class way_order_tracker;
  bit [2:0]     order [64][8];
  bit [15:0]    lfsr;
  srip_pkg::insert_mode_t ins_mode;
  srip_pkg::victim_mode_t vic_mode;
  bit [3:0]     ways_reg;
  bit [2:0]     victims_due[$];
  int           errors;
  int           checked;

  function new();
    for (int s = 0; s < 64; s++) begin
      for (int w = 0; w < 8; w++) order[s][w] = w[2:0];
    end
    lfsr     = srip_pkg::LFSR_SEED;
    ins_mode = srip_pkg::INS_MRU;
    vic_mode = srip_pkg::VIC_LRU;
    ways_reg = srip_pkg::WAYS_RESET;
    errors   = 0;
    checked  = 0;
  endfunction

  // A register value of zero behaves as one way, anything above eight as eight.
  function int ways_used();
    if (ways_reg == 0) return 1;
    if (ways_reg > 8) return 8;
    return ways_reg;
  endfunction

  function void set_reg(logic [srip_pkg::CFG_IDX_W-1:0] idx, logic [srip_pkg::CFG_W-1:0] val);
    case (idx)
      srip_pkg::CFG_INSERT_MODE: ins_mode = srip_pkg::insert_mode_t'(val[1:0]);
      srip_pkg::CFG_VICTIM_MODE: vic_mode = srip_pkg::victim_mode_t'(val[0]);
      srip_pkg::CFG_WAYS_IN_USE: ways_reg = val;
      default: ;
    endcase
  endfunction

  // Fibonacci LFSR, taps 16, 14, 13 and 11; the advanced value is returned.
  function bit [15:0] draw();
    bit fb;
    fb   = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
    lfsr = {fb, lfsr[15:1]};
    return lfsr;
  endfunction

  function int find_way(int s, int a, bit [2:0] way);
    for (int i = 0; i < a; i++) begin
      if (order[s][i] == way) return i;
    end
    return a;
  endfunction

  // A way that is missing from the list goes to the front, and the tail entry drops out.
  function void move_front(int s, int a, bit [2:0] way);
    int pos;
    pos = find_way(s, a, way);
    if (pos >= a) pos = a - 1;
    for (int i = pos; i > 0; i--) order[s][i] = order[s][i-1];
    order[s][0] = way;
  endfunction

  // A way that is missing from the list goes to the front instead.
  function void move_tail(int s, int a, bit [2:0] way);
    int pos;
    pos = find_way(s, a, way);
    if (pos >= a) begin
      move_front(s, a, way);
      return;
    end
    for (int i = pos + 1; i < a; i++) order[s][i-1] = order[s][i];
    order[s][a-1] = way;
  endfunction

  function void accept_item(bit cmd, bit [5:0] s, bit [2:0] way, bit fill);
    int a;
    int v;
    a = ways_used();
    if (cmd) begin
      if (vic_mode == srip_pkg::VIC_RANDOM) v = draw() % a;
      else v = order[s][a-1];
      victims_due.push_back(v[2:0]);
      return;
    end
    case (ins_mode)
      srip_pkg::INS_MRU: move_front(s, a, way);
      srip_pkg::INS_LIP: begin
        if (fill) move_tail(s, a, way);
        else move_front(s, a, way);
      end
      srip_pkg::INS_BIP: begin
        if (!fill) move_front(s, a, way);
        else if ((draw() % srip_pkg::BIP_ODDS) == 0) move_front(s, a, way);
        else move_tail(s, a, way);
      end
      default: begin
        if (fill) move_front(s, a, way);
      end
    endcase
  endfunction

  function void check_victim(logic [2:0] got);
    bit [2:0] want;
    if (victims_due.size() == 0) begin
      $display("%0t: victim way %0d arrived with nothing expected", $time, got);
      errors++;
      return;
    end
    want = victims_due.pop_front();
    checked++;
    if (got !== want) begin
      $display("%0t: victim way mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_set_recency_insertion_policy;
  import srip_pkg::*;

  localparam logic CMD_COMMIT = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;
  localparam int   NUM_PHASES = 12;
  localparam int   PHASE_ITEMS = 128;
  // A random victim waits on the remainder unit and two more items may sit in the
  // queue; this quiet stretch is long enough to leave the back part well and truly idle.
  localparam int   SETTLE_CYCLES = 64;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_command = 1'b0;
  logic [SET_NUM_W-1:0] in_set_index = '0;
  logic [WAY_NUM_W-1:0] in_way_number = '0;
  logic                 in_first_fill = 1'b0;
  logic                 out_valid;
  logic [WAY_NUM_W-1:0] out_victim_way;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  way_order_tracker tracker = new();

  int  n_items = 0;
  int  n_victims = 0;
  int  n_settings = 0;
  bit  no_gaps = 1'b0;

  set_recency_insertion_policy dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_set_index  (in_set_index),
    .in_way_number (in_way_number),
    .in_first_fill (in_first_fill),
    .out_valid     (out_valid),
    .out_victim_way(out_victim_way),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Every result is on the ports for one cycle only, so the monitor looks at
  // each rising edge. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) tracker.check_victim(out_victim_way);
  end

  // Hard stop in case the block stops accepting transfers or goes quiet.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly back-to-back or short gaps, now and then a long one. While
  // no_gaps is set the sender keeps start high across whole stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one item and holds it until the block takes it. The transfer
  // happens at the first rising edge that sees busy low; start stays high
  // afterwards, so the caller decides whether a gap follows.
  task automatic send(input logic cmd, input logic [SET_NUM_W-1:0] s,
                      input logic [WAY_NUM_W-1:0] way, input logic fill);
    start         <= 1'b1;
    in_command    <= cmd;
    in_set_index  <= s;
    in_way_number <= way;
    in_first_fill <= fill;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.accept_item(cmd, s, way, fill);
    n_items++;
    if (cmd == CMD_VICTIM) n_victims++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Commits yield no result, so an empty list of owed victims does not mean
  // the back part is done: a fixed number of quiet cycles follows.
  task automatic settle();
    start <= 1'b0;
    while (tracker.victims_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges while the block is idle.
  // The mode registers get random junk in their unused upper bits.
  task automatic program_regs(input insert_mode_t ins, input victim_mode_t vic,
                              input logic [CFG_W-1:0] ways);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0]     val [3];
    idx[0] = CFG_INSERT_MODE;
    idx[1] = CFG_VICTIM_MODE;
    idx[2] = CFG_WAYS_IN_USE;
    val[0] = {2'($urandom_range(0, 3)), ins};
    val[1] = {3'($urandom_range(0, 7)), vic};
    val[2] = ways;
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      tracker.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    logic [CFG_W-1:0] ways_pick [NUM_PHASES];
    logic             cmd;
    logic [5:0]       s;
    logic [2:0]       way;
    int               a;

    // The ways settings include the saturating extremes: zero acts as one
    // and anything above eight acts as eight.
    ways_pick = '{4'd8, 4'd1, 4'd0, 4'd2, 4'd15, 4'd3, 4'd7, 4'd9, 4'd5, 4'd4, 4'd6, 4'd8};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears every row after reset and holds busy high meanwhile.
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // Directed part, reset settings: MRU insertion, tail victims, 8 ways.
    // Rows start in identity order, so the first victim is the last way.
    send(CMD_VICTIM, 6'd0, 3'd0, 1'b0);
    send(CMD_COMMIT, 6'd0, 3'd7, 1'b0);
    send(CMD_VICTIM, 6'd0, 3'd5, 1'b1);
    send(CMD_COMMIT, 6'd63, 3'd0, 1'b1);
    send(CMD_VICTIM, 6'd63, 3'd7, 1'b1);

    // LIP with three ways. A fill of a way outside the list lands at the
    // front, a fill of a listed way sinks to the tail, and a hit on an
    // unlisted way goes to the front and pushes the tail entry out.
    program_regs(INS_LIP, VIC_LRU, 4'd3);
    send(CMD_COMMIT, 6'd42, 3'd6, 1'b1);
    send(CMD_VICTIM, 6'd42, 3'd0, 1'b0);
    send(CMD_COMMIT, 6'd42, 3'd1, 1'b1);
    send(CMD_VICTIM, 6'd42, 3'd0, 1'b0);
    send(CMD_COMMIT, 6'd42, 3'd7, 1'b0);
    send(CMD_VICTIM, 6'd42, 3'd0, 1'b0);

    // BIP with random victims and a ways register of zero (one way in use).
    program_regs(INS_BIP, VIC_RANDOM, 4'd0);
    send(CMD_COMMIT, 6'd21, 3'd3, 1'b1);
    send(CMD_COMMIT, 6'd21, 3'd4, 1'b0);
    send(CMD_VICTIM, 6'd21, 3'd7, 1'b1);

    // FIFO with the ways register above its range: hits leave the list alone.
    program_regs(INS_FIFO, VIC_LRU, 4'd15);
    send(CMD_COMMIT, 6'd9, 3'd2, 1'b0);
    send(CMD_VICTIM, 6'd9, 3'd0, 1'b0);
    send(CMD_COMMIT, 6'd9, 3'd7, 1'b1);
    send(CMD_VICTIM, 6'd9, 3'd0, 1'b0);

    program_regs(INS_FIFO, VIC_RANDOM, 4'd8);
    send(CMD_VICTIM, 6'd9, 3'd0, 1'b0);
    send(CMD_VICTIM, 6'd10, 3'd0, 1'b0);

    // Random part. The first eight settings pair every insertion mode with
    // both victim modes; the rest use random victims again. Most items hit a
    // handful of sets so their lists get reordered many times over, and most
    // commits name a way that is inside the used part of the list.
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_regs(insert_mode_t'(p % 4), victim_mode_t'(p < 8 ? (p >> 2) & 1 : 1),
                   ways_pick[p]);
      a = tracker.ways_used();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        cmd = ($urandom_range(0, 99) < 30) ? CMD_VICTIM : CMD_COMMIT;
        s   = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3))
                                          : 6'($urandom_range(0, 63));
        way = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, a - 1))
                                          : 3'($urandom_range(0, 7));
        send(cmd, s, way, 1'($urandom_range(0, 1)));
        pause(pick_gap());
      end
    end

    settle();

    if (tracker.victims_due.size() != 0) begin
      $display("%0t: %0d victim ways never arrived", $time, tracker.victims_due.size());
      tracker.errors++;
    end

    $display("Sent %0d items (%0d victim requests) over %0d register settings;",
             n_items, n_victims, n_settings + 1);
    $display("compared %0d victim ways, %0d mismatches.", tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/srip_pkg.sv
design/srip_rem.sv
design/srip_front.sv
design/srip_back.sv
design/set_recency_insertion_policy.sv
dv/tb_set_recency_insertion_policy.sv
